>>> sv/ftrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrt_pkg: five-tuple rule table shared definitions
// Sizes, operation and status codes, and request/result/rule record types.
// ----------------------------------------------------------------------------
package ftrt_pkg;

    localparam int MAX_RULES   = 128;
    localparam int IDX_W       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W       = $clog2(MAX_RULES + 1);
    localparam int HELD_W      = 8;
    // power of two, so the queue pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    localparam logic RULE_PERMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  proto_number;
        logic        rule_action;
    } in_item_t;

    typedef struct packed {
        logic              permit;
        logic [1:0]        status;
        logic [HELD_W-1:0] rules_held;
    } out_item_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  proto_number;
        logic        rule_action;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    typedef struct packed {
        logic [1:0] op;
        rule_t      key;
    } queue_entry_t;

endpackage : ftrt_pkg
`default_nettype wire

>>> sv/ftrt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrt_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ftrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule : ftrt_ram
`default_nettype wire

>>> sv/ftrt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrt_front: request intake and classification
// Decodes each request's mode into an operation and holds it in a short queue
// until the table engine takes it.
// ----------------------------------------------------------------------------
module ftrt_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire ftrt_pkg::in_item_t    in_item,
    output      logic                  q_valid,
    output      ftrt_pkg::queue_entry_t q_entry,
    input  wire logic                  q_pop
);
    import ftrt_pkg::*;

    queue_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0]  fill_reg, fill_next;
    logic                push;
    queue_entry_t        classified;

    always_comb
    begin
        classified.key.source_address = in_item.source_address;
        classified.key.dest_address   = in_item.dest_address;
        classified.key.source_port    = in_item.source_port;
        classified.key.dest_port      = in_item.dest_port;
        classified.key.proto_number   = in_item.proto_number;
        classified.key.rule_action    = in_item.rule_action;
        case (in_item.mode)
            MODE_LOOKUP: classified.op = OP_LOOKUP;
            MODE_ADD:    classified.op = OP_ADD;
            MODE_DELETE: classified.op = OP_DELETE;
            default:     classified.op = OP_NONE;
        endcase
    end

    assign in_stall = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + QFILL_W'(1);
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - QFILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule : ftrt_front
`default_nettype wire

>>> sv/ftrt_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrt_engine: rule table engine
// Holds the rule RAM and count, runs add, lookup and delete one request at a
// time, and registers the result.
// ----------------------------------------------------------------------------
module ftrt_engine (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   policy_permit,
    input  wire logic                   q_valid,
    input  wire ftrt_pkg::queue_entry_t q_entry,
    output      logic                   q_pop,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      ftrt_pkg::out_item_t    out_item
);
    import ftrt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MOVE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic [1:0]       op_reg, op_next;
    rule_t            key_reg, key_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    rule_t            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [RULE_W-1:0] ram_rdata;
    rule_t            rd_rule;

    logic             out_free;
    logic             hit;
    logic [CNT_W-1:0] count_dec;
    logic [IDX_W-1:0] last_idx;

    // packet matches the rule directly or with the endpoints swapped
    function automatic logic tuple_match(rule_t r, rule_t k);
        logic fwd;
        logic rev;
        fwd = (k.source_address == r.source_address) && (k.dest_address == r.dest_address)
              && (k.source_port == r.source_port) && (k.dest_port == r.dest_port);
        rev = (k.source_address == r.dest_address) && (k.dest_address == r.source_address)
              && (k.source_port == r.dest_port) && (k.dest_port == r.source_port);
        return (k.proto_number == r.proto_number) && (fwd || rev);
    endfunction

    ftrt_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rule   = rule_t'(ram_rdata);
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign hit       = (op_reg == OP_LOOKUP) ? tuple_match(rd_rule, key_reg)
                                             : (rd_rule == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = key_reg;
        ram_raddr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_entry.op;
                    key_next = q_entry.key;
                    out_item_next.permit     = 1'b0;
                    out_item_next.status     = STATUS_OK;
                    out_item_next.rules_held = HELD_W'(count_reg);
                    case (q_entry.op)
                        OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg < CNT_W'(MAX_RULES))
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = q_entry.key;
                                count_next = count_reg + CNT_W'(1);
                                out_item_next.rules_held = HELD_W'(count_reg + CNT_W'(1));
                            end
                            else
                            begin
                                out_item_next.status = STATUS_FULL;
                            end
                        end
                        OP_LOOKUP, OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                if (q_entry.op == OP_LOOKUP)
                                begin
                                    out_item_next.permit = policy_permit;
                                end
                                else
                                begin
                                    out_item_next.status = STATUS_ABSENT;
                                end
                            end
                            else
                            begin
                                // first read goes out with the request pop
                                ram_raddr      = '0;
                                cmp_valid_next = 1'b1;
                                cmp_idx_next   = '0;
                                ptr_next       = CNT_W'(1);
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // slot cmp_idx_reg is on the RAM output; the next slot is read
                if (cmp_valid_reg && hit)
                begin
                    cmp_valid_next = 1'b0;
                    if (op_reg == OP_LOOKUP)
                    begin
                        out_valid_next           = 1'b1;
                        out_item_next.permit     = (rd_rule.rule_action == RULE_PERMIT);
                        out_item_next.status     = STATUS_OK;
                        out_item_next.rules_held = HELD_W'(count_reg);
                        state_next               = ST_IDLE;
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        count_next               = count_dec;
                        out_valid_next           = 1'b1;
                        out_item_next.permit     = 1'b0;
                        out_item_next.status     = STATUS_OK;
                        out_item_next.rules_held = HELD_W'(count_dec);
                        state_next               = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the last rule to fill the hole
                        ram_raddr  = last_idx;
                        hit_next   = cmp_idx_reg;
                        state_next = ST_MOVE;
                    end
                end
                else if (cmp_valid_reg && (cmp_idx_reg == last_idx))
                begin
                    cmp_valid_next           = 1'b0;
                    out_valid_next           = 1'b1;
                    out_item_next.rules_held = HELD_W'(count_reg);
                    if (op_reg == OP_LOOKUP)
                    begin
                        out_item_next.permit = policy_permit;
                        out_item_next.status = STATUS_OK;
                    end
                    else
                    begin
                        out_item_next.permit = 1'b0;
                        out_item_next.status = STATUS_ABSENT;
                    end
                    state_next = ST_IDLE;
                end
                else if (ptr_reg < count_reg)
                begin
                    ram_raddr      = ptr_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end

            ST_MOVE:
            begin
                ram_we                   = 1'b1;
                ram_waddr                = hit_reg;
                ram_wdata                = rd_rule;
                count_next               = count_dec;
                out_valid_next           = 1'b1;
                out_item_next.permit     = 1'b0;
                out_item_next.status     = STATUS_OK;
                out_item_next.rules_held = HELD_W'(count_dec);
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_reg      <= hit_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule : ftrt_engine
`default_nettype wire

>>> sv/five_tuple_rule_table_top.sv
`default_nettype none
// Five-tuple packet filter rule table. Requests are lookups, rule adds and
// rule deletes; each gives one result with verdict, status and rule count.
// An add, an unused mode, or a lookup/delete on an empty table needs no scan.
// A lookup or delete reads the rule RAM one slot per cycle from slot 0 up to
// the first hit or the last rule held (at most 128 rules); a delete that hits
// below the last slot then moves the last rule into the hole.
// A two-entry request queue keeps intake open while the engine scans, and the
// result register holds a result while downstream stalls; the engine takes no
// new request until that result is taken.
// ----------------------------------------------------------------------------
// five_tuple_rule_table_top: packet filter rule table
// Policy register, request queue and rule table engine.
// ----------------------------------------------------------------------------
module five_tuple_rule_table_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_data,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire ftrt_pkg::in_item_t  in_item,
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      ftrt_pkg::out_item_t out_item
);
    import ftrt_pkg::*;

    logic         policy_permit_reg;
    logic         q_valid;
    queue_entry_t q_entry;
    logic         q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_permit_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            policy_permit_reg <= cfg_data;
        end
    end

    ftrt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    ftrt_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .policy_permit (policy_permit_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

    // count in a result never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.rules_held <= HELD_W'(MAX_RULES)))
        else $error("rules_held above table size");

    // full status only with a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status == STATUS_FULL))
            |-> (out_item.rules_held == HELD_W'(MAX_RULES)))
        else $error("full status with room left");

    // a permit verdict always carries ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.permit) |-> (out_item.status == STATUS_OK))
        else $error("permit with error status");

    // the engine only takes a request that the queue holds
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty request queue");

endmodule : five_tuple_rule_table_top
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: five-tuple rule table testbench
// Sends lookup, add, delete and unused-mode requests with random gaps and
// output stalls, keeps a local copy of the rule table to predict each result,
// and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ftrt_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_PCT   = 34;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_data = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    // local copy of the rule table and policy
    rule_t     rule_store [MAX_RULES];
    int        rules_stored = 0;
    logic      policy_allow = 1'b1;

    in_item_t  req_backlog [$];
    out_item_t pending_verdicts [$];
    rule_t     rule_pool [$];
    out_item_t want;

    logic      steady_run = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;

    five_tuple_rule_table_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #2 clk = ~clk;

    function automatic logic tuple_hit(rule_t r, rule_t k);
        if (r.proto_number != k.proto_number)
            return 1'b0;
        if (r.source_address == k.source_address && r.dest_address == k.dest_address &&
            r.source_port == k.source_port && r.dest_port == k.dest_port)
            return 1'b1;
        return r.source_address == k.dest_address && r.dest_address == k.source_address &&
               r.source_port == k.dest_port && r.dest_port == k.source_port;
    endfunction

    // applies one request to the local table and returns its result
    function automatic out_item_t table_verdict(in_item_t req);
        out_item_t res;
        rule_t     key;
        int        hit;
        key = rule_t'(req[RULE_W-1:0]);
        hit = -1;
        res = '0;
        res.status = STATUS_OK;
        case (req.mode)
            MODE_LOOKUP:
            begin
                res.permit = policy_allow;
                for (int i = 0; i < rules_stored && hit < 0; i++)
                    if (tuple_hit(rule_store[i], key))
                        hit = i;
                if (hit >= 0)
                    res.permit = (rule_store[hit].rule_action == RULE_PERMIT);
            end
            MODE_ADD:
            begin
                if (rules_stored < MAX_RULES)
                begin
                    rule_store[rules_stored] = key;
                    rules_stored++;
                end
                else
                    res.status = STATUS_FULL;
            end
            MODE_DELETE:
            begin
                res.status = STATUS_ABSENT;
                for (int i = 0; i < rules_stored && hit < 0; i++)
                    if (rule_store[i] == key)
                        hit = i;
                if (hit >= 0)
                begin
                    rule_store[hit] = rule_store[rules_stored - 1];
                    rules_stored--;
                    res.status = STATUS_OK;
                end
            end
            default: ;
        endcase
        res.rules_held = HELD_W'(rules_stored);
        return res;
    endfunction

    function automatic rule_t swap_ends(rule_t r);
        rule_t s;
        s = r;
        s.source_address = r.dest_address;
        s.dest_address   = r.source_address;
        s.source_port    = r.dest_port;
        s.dest_port      = r.source_port;
        return s;
    endfunction

    function automatic rule_t random_rule();
        rule_t r;
        r.source_address = $urandom;
        r.dest_address   = $urandom;
        r.source_port    = 16'($urandom);
        r.dest_port      = 16'($urandom);
        r.proto_number   = 8'($urandom);
        r.rule_action    = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic push_req(input logic [1:0] mode, input rule_t r);
        req_backlog.push_back(in_item_t'({mode, r}));
    endtask

    // mostly adds, deletes and lookups of known rules; some misses and noise
    task automatic queue_mix(input int n, input int add_pct, input int del_pct);
        rule_t r;
        int    pick;
        int    idx;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            r = random_rule();
            if (pick < add_pct || rule_pool.size() == 0)
            begin
                // sometimes re-add a known tuple with the other action
                if (rule_pool.size() != 0 && $urandom_range(9) == 0)
                begin
                    r = rule_pool[$urandom_range(rule_pool.size() - 1)];
                    r.rule_action = ~r.rule_action;
                end
                rule_pool.push_back(r);
                push_req(MODE_ADD, r);
            end
            else if (pick < add_pct + del_pct)
            begin
                idx = $urandom_range(rule_pool.size() - 1);
                r = rule_pool[idx];
                if ($urandom_range(7) == 0)
                    r.source_port ^= 16'h0001;
                else
                    rule_pool.delete(idx);
                push_req(MODE_DELETE, r);
            end
            else if (pick < 90)
            begin
                r = rule_pool[$urandom_range(rule_pool.size() - 1)];
                if ($urandom_range(1) == 1)
                    r = swap_ends(r);
                if ($urandom_range(9) == 0)
                    r.proto_number ^= 8'h80;
                r.rule_action = 1'($urandom_range(1));
                push_req(MODE_LOOKUP, r);
            end
            else if (pick < 96)
                push_req(MODE_LOOKUP, r);
            else
                push_req(MODE_UNUSED, r);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_policy(input logic v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        policy_allow = v;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_verdicts.push_back(table_verdict(in_item));
            if (!in_valid || !in_stall)
            begin
                if (req_backlog.size() != 0 &&
                    (steady_run || $urandom_range(99) >= STALL_PCT))
                begin
                    in_valid <= 1'b1;
                    in_item  <= req_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    $error("result with no request outstanding");
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (out_item.permit !== want.permit)
                    begin
                        mismatches++;
                        $error("permit: expected %0d, got %0d", want.permit, out_item.permit);
                    end
                    if (out_item.status !== want.status)
                    begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                    end
                    if (out_item.rules_held !== want.rules_held)
                    begin
                        mismatches++;
                        $error("rules_held: expected %0d, got %0d",
                               want.rules_held, out_item.rules_held);
                    end
                end
                results_seen++;
            end
            // one long hold-off so the request queue backs up
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady_run && ($urandom_range(99) < STALL_PCT);
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rule_t ra;
        rule_t rb;
        rule_t rc;
        rule_t r;
        ra = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1};
        rb = '0;
        rc = '{32'h0A00_0001, 32'hC0A8_0102, 16'd1234, 16'd80, 8'd6, 1'b0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, unused mode, then a few rules
        push_req(MODE_LOOKUP, rc);
        push_req(MODE_DELETE, rc);
        push_req(MODE_UNUSED, rb);
        push_req(MODE_ADD, ra);
        push_req(MODE_ADD, rb);
        push_req(MODE_ADD, rc);
        push_req(MODE_LOOKUP, ra);
        push_req(MODE_LOOKUP, rb);
        push_req(MODE_LOOKUP, rc);
        push_req(MODE_LOOKUP, swap_ends(rc));
        r = rc;
        r.proto_number = 8'd17;
        push_req(MODE_LOOKUP, r);
        // addresses swapped but ports not: no match
        r = rc;
        r.source_address = rc.dest_address;
        r.dest_address   = rc.source_address;
        push_req(MODE_LOOKUP, r);
        r = rc;
        r.rule_action = 1'b1;
        push_req(MODE_DELETE, r);
        // same tuple, other action: first rule must win
        r = ra;
        r.rule_action = 1'b0;
        push_req(MODE_ADD, r);
        push_req(MODE_LOOKUP, ra);
        push_req(MODE_DELETE, ra);
        push_req(MODE_LOOKUP, ra);
        // rc now sits in the last slot
        push_req(MODE_DELETE, rc);
        push_req(MODE_LOOKUP, rc);
        push_req(MODE_UNUSED, ra);
        wait_drained();

        write_policy(1'b0);
        push_req(MODE_LOOKUP, rc);
        push_req(MODE_LOOKUP, rb);
        // fill the table past full, then scan it
        for (int k = 0; k < 132; k++)
        begin
            r = random_rule();
            rule_pool.push_back(r);
            push_req(MODE_ADD, r);
        end
        for (int k = 0; k < 10; k++)
        begin
            r = rule_pool[$urandom_range(rule_pool.size() - 1)];
            push_req(MODE_LOOKUP, $urandom_range(1) ? swap_ends(r) : r);
        end
        wait_drained();

        write_policy(1'b1);
        queue_mix(48, 20, 45);
        for (int b = 0; b < 5; b++)
        begin
            wait_drained();
            write_policy((b % 2 == 0) ? 1'b0 : 1'b1);
            steady_run = (b == 1);
            queue_mix(48, 25 + 5 * b, 30 - 2 * b);
        end
        wait_drained();
        steady_run = 1'b0;
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
